// File: hdl/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared constants, opcodes and control structs of the RV32I execute block.
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam int C_MEM_WORDS = 4096;
    localparam int C_MEM_AW    = $clog2(C_MEM_WORDS);
    localparam logic [31:0] C_STACK_OFS = 32'(4 * C_MEM_WORDS);

    localparam logic REQ_PRELOAD = 1'b0;
    localparam logic REQ_EXEC    = 1'b1;

    localparam logic [6:0] OP_MATH   = 7'h33;
    localparam logic [6:0] OP_MATHI  = 7'h13;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_LUI    = 7'h37;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_B  = 3'd0;
    localparam logic [2:0] F3_H  = 3'd1;
    localparam logic [2:0] F3_W  = 3'd2;
    localparam logic [2:0] F3_BU = 3'd4;
    localparam logic [2:0] F3_HU = 3'd5;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    typedef struct packed {
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        load;
        logic        store;
        logic [2:0]  f3;
        logic [31:0] addr;
        logic        unknown;
        logic [31:0] npc;
        logic        halt;
    } t_ex_res;

    typedef struct packed {
        logic        re;
        logic [4:0]  a1;
        logic [4:0]  a2;
    } t_rf_rd;

    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

endpackage

// File: hdl/rvx_req_if.sv
// ----------------------------------------------------------------------------
// rvx_req_if
// Request channel: preload or execute items.
// ----------------------------------------------------------------------------
interface rvx_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [11:0] preload_index;
    logic [31:0] preload_word;
    logic [31:0] instruction;

    modport source (output valid, req_type, preload_index, preload_word, instruction,
                    input ready);
    modport sink   (input valid, req_type, preload_index, preload_word, instruction,
                    output ready);
endinterface

// File: hdl/rvx_res_if.sv
// ----------------------------------------------------------------------------
// rvx_res_if
// Result channel: one result per request.
// ----------------------------------------------------------------------------
interface rvx_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_written;
    logic        store_done;
    logic [31:0] access_address;
    logic        unknown_op;
    logic        halted;

    modport source (output valid, next_pc, dest_index, dest_value, dest_written,
                    store_done, access_address, unknown_op, halted,
                    input ready);
    modport sink   (input valid, next_pc, dest_index, dest_value, dest_written,
                    store_done, access_address, unknown_op, halted,
                    output ready);
endinterface

// File: hdl/rvx_cfg_if.sv
// ----------------------------------------------------------------------------
// rvx_cfg_if
// Configuration write channel for the memory base register.
// ----------------------------------------------------------------------------
interface rvx_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] memory_base;

    modport source (output valid, memory_base, input ready);
    modport sink   (input valid, memory_base, output ready);
endinterface

// File: hdl/rv32i_instruction_execute.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_execute
// RV32I execute block: register file and data memory in synchronous RAMs.
//
//  channel  | dir | payload
//  i_cfg    | in  | memory_base
//  i_req    | in  | req_type, preload_index, preload_word, instruction
//  o_res    | out | next_pc, dest_*, store_done, access_address, unknown_op, halted
//
// One request per cycle while results are taken; stages: register read,
// execute with memory read, write-back into the output register. Register and
// memory results are forwarded from write-back into execute, so no interlock.
// Reset is synchronous; register file entries read as reset values until
// written, no clearing pass. A stalled result holds the whole pipeline.
// ----------------------------------------------------------------------------
module rv32i_instruction_execute
    import rvx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rvx_cfg_if.sink   i_cfg,
    rvx_req_if.sink   i_req,
    rvx_res_if.source o_res
);

    logic        advance, accept;
    logic [31:0] r_base, r_pc;
    logic        r_halt;

    logic        r_e_vld, r_e_type;
    logic [11:0] r_e_pidx;
    logic [31:0] r_e_pword, r_e_ins;

    logic                r_m_vld, r_m_pre;
    t_ex_res             r_m;
    logic [31:0]         r_m_b, r_m_pword;
    logic [C_MEM_AW-1:0] r_m_widx;

    logic                r_o_vld;
    logic [31:0]         r_o_npc, r_o_val, r_o_addr;
    logic [4:0]          r_o_rd;
    logic                r_o_wr, r_o_st, r_o_unk, r_o_halt;

    t_rf_rd      rf_rd;
    t_rf_wr      rf_wr;
    logic [31:0] rf_a, rf_b, fa, fb;
    t_ex_res     ex;
    logic [31:0] addr_off, pidx_ext;
    logic [C_MEM_AW-1:0] e_widx;
    logic [31:0] d_rdata, m_val, m_word, lmask, ldata;
    logic [4:0]  bsh, hsh;
    logic        m_we, dm_we;

    assign advance     = !r_o_vld || o_res.ready;
    assign accept      = i_req.valid && advance;
    assign i_req.ready = advance;
    assign i_cfg.ready = 1'b1;

    // Base and PC load on a base write; PC and halt advance as requests leave execute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_pc   <= '0;
            r_halt <= 1'b0;
        end else if (i_cfg.valid) begin
            r_base <= i_cfg.memory_base;
            r_pc   <= i_cfg.memory_base;
        end else if (advance && r_e_vld) begin
            r_pc   <= ex.npc;
            r_halt <= ex.halt;
        end
    end

    // Register read request
    always_comb begin
        rf_rd.re = accept;
        rf_rd.a1 = i_req.instruction[19:15];
        rf_rd.a2 = i_req.instruction[24:20];
    end

    // Execute stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (advance) begin
            r_e_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e_type  <= i_req.req_type;
            r_e_pidx  <= i_req.preload_index;
            r_e_pword <= i_req.preload_word;
            r_e_ins   <= i_req.instruction;
        end
    end

    // Forward write-back into execute operands
    assign m_we = r_m_vld && r_m.wr && (r_m.rd != 5'd0);
    assign fa = (m_we && r_m.rd == r_e_ins[19:15]) ? m_val : rf_a;
    assign fb = (m_we && r_m.rd == r_e_ins[24:20]) ? m_val : rf_b;

    rvx_exec u_exec (
        .i_req_type (r_e_type),
        .i_ins      (r_e_ins),
        .i_pc       (r_pc),
        .i_halt     (r_halt),
        .i_a        (fa),
        .i_b        (fb),
        .o_res      (ex)
    );

    // Word index of the access
    assign addr_off = ex.addr - r_base;
    assign pidx_ext = 32'(r_e_pidx);
    assign e_widx   = (r_e_type == REQ_PRELOAD) ? pidx_ext[C_MEM_AW-1:0]
                                                : addr_off[C_MEM_AW+1:2];

    // Write-back stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (advance) begin
            r_m_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_e_vld) begin
            r_m       <= ex;
            r_m_b     <= fb;
            r_m_pre   <= (r_e_type == REQ_PRELOAD);
            r_m_pword <= r_e_pword;
            r_m_widx  <= e_widx;
        end
    end

    // Load lane extraction and store merge
    assign bsh = {r_m.addr[1:0], 3'b000};
    assign hsh = {r_m.addr[1], 4'b0000};
    always_comb begin
        ldata = d_rdata;
        lmask = 32'd0;
        case (r_m.f3)
            F3_B:    ldata = {{24{d_rdata[bsh+7]}}, 8'(d_rdata >> bsh)};
            F3_BU:   ldata = {24'd0, 8'(d_rdata >> bsh)};
            F3_H:    ldata = {{16{d_rdata[hsh+15]}}, 16'(d_rdata >> hsh)};
            F3_HU:   ldata = {16'd0, 16'(d_rdata >> hsh)};
            default: ldata = d_rdata;
        endcase
        case (r_m.f3)
            F3_B: begin
                lmask  = 32'h0000_00FF << bsh;
                m_word = (d_rdata & ~lmask) | ((32'(r_m_b[7:0])) << bsh);
            end
            F3_H: begin
                lmask  = 32'h0000_FFFF << hsh;
                m_word = (d_rdata & ~lmask) | ((32'(r_m_b[15:0])) << hsh);
            end
            default: m_word = r_m_b;
        endcase
        if (r_m_pre) begin
            m_word = r_m_pword;
        end
    end

    assign m_val = r_m.load ? ldata : r_m.val;
    assign dm_we = advance && r_m_vld && (r_m_pre || r_m.store);

    always_comb begin
        rf_wr.we   = advance && m_we;
        rf_wr.addr = r_m.rd;
        rf_wr.data = m_val;
    end

    rvx_regfile u_rf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (rf_rd),
        .i_wr     (rf_wr),
        .i_clr_sp (i_cfg.valid),
        .i_base   (r_base),
        .o_data1  (rf_a),
        .o_data2  (rf_b)
    );

    rvx_dmem u_dmem (
        .i_clk   (i_clk),
        .i_re    (advance && r_e_vld),
        .i_raddr (e_widx),
        .i_we    (dm_we),
        .i_waddr (r_m_widx),
        .i_wdata (m_word),
        .o_rdata (d_rdata)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (advance) begin
            r_o_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_m_vld) begin
            r_o_npc  <= r_m.npc;
            r_o_rd   <= r_m.wr ? r_m.rd : 5'd0;
            r_o_val  <= r_m.wr ? m_val : 32'd0;
            r_o_wr   <= m_we;
            r_o_st   <= r_m.store;
            r_o_addr <= r_m.addr;
            r_o_unk  <= r_m.unknown;
            r_o_halt <= r_m.halt;
        end
    end

    assign o_res.valid          = r_o_vld;
    assign o_res.next_pc        = r_o_npc;
    assign o_res.dest_index     = r_o_rd;
    assign o_res.dest_value     = r_o_val;
    assign o_res.dest_written   = r_o_wr;
    assign o_res.store_done     = r_o_st;
    assign o_res.access_address = r_o_addr;
    assign o_res.unknown_op     = r_o_unk;
    assign o_res.halted         = r_o_halt;

`ifndef SYNTHESIS
    // No request taken while a result is held
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !o_res.ready) |-> !i_req.ready)
        else $error("request accepted while output stalled");

    // Halt flag never clears
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");

    // Write-back holds while output stalls
    a_wb_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_vld && !advance) |=> r_m_vld)
        else $error("write-back request lost during stall");
`endif

endmodule

// File: hdl/rvx_regfile.sv
// ----------------------------------------------------------------------------
// rvx_regfile
// 32 x 32 register file, two registered read ports, one write port.
// ----------------------------------------------------------------------------
module rvx_regfile
    import rvx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rf_rd      i_rd,
    input  t_rf_wr      i_wr,
    input  logic        i_clr_sp,
    input  logic [31:0] i_base,
    output logic [31:0] o_data1,
    output logic [31:0] o_data2
);

    logic [31:0] mem [32];
    logic [31:0] r_vld;
    logic [31:0] sp_rst;

    assign sp_rst = i_base + C_STACK_OFS;

    // Track written entries; unwritten ones read as their reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr_sp) begin
            r_vld[2] <= 1'b0;
        end else if (i_wr.we) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read ports with write-through bypass
    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            if (i_wr.we && i_wr.addr == i_rd.a1) begin
                o_data1 <= i_wr.data;
            end else if (r_vld[i_rd.a1]) begin
                o_data1 <= mem[i_rd.a1];
            end else begin
                o_data1 <= (i_rd.a1 == 5'd2) ? sp_rst : 32'd0;
            end
            if (i_wr.we && i_wr.addr == i_rd.a2) begin
                o_data2 <= i_wr.data;
            end else if (r_vld[i_rd.a2]) begin
                o_data2 <= mem[i_rd.a2];
            end else begin
                o_data2 <= (i_rd.a2 == 5'd2) ? sp_rst : 32'd0;
            end
        end
    end

endmodule

// File: hdl/rvx_dmem.sv
// ----------------------------------------------------------------------------
// rvx_dmem
// Word-wide data memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rvx_dmem
    import rvx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_re,
    input  logic [C_MEM_AW-1:0] i_raddr,
    input  logic                i_we,
    input  logic [C_MEM_AW-1:0] i_waddr,
    input  logic [31:0]         i_wdata,
    output logic [31:0]         o_rdata
);

    logic [31:0] mem [C_MEM_WORDS];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; pass the new word through on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && i_waddr == i_raddr) begin
                o_rdata <= i_wdata;
            end else begin
                o_rdata <= mem[i_raddr];
            end
        end
    end

endmodule

// File: hdl/rvx_exec.sv
// ----------------------------------------------------------------------------
// rvx_exec
// Decode, ALU, branch and address logic for one instruction.
// ----------------------------------------------------------------------------
module rvx_exec
    import rvx_pkg::*;
(
    input  logic        i_req_type,
    input  logic [31:0] i_ins,
    input  logic [31:0] i_pc,
    input  logic        i_halt,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_ex_res     o_res
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic        f7_nz;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
    logic [31:0] y;
    logic [4:0]  sh;
    logic [31:0] pc4;

    assign opc   = i_ins[6:0];
    assign f3    = i_ins[14:12];
    assign f7_nz = |i_ins[31:25];
    assign imm_i = {{20{i_ins[31]}}, i_ins[31:20]};
    assign imm_s = {{20{i_ins[31]}}, i_ins[31:25], i_ins[11:7]};
    assign imm_b = {{19{i_ins[31]}}, i_ins[31], i_ins[7], i_ins[30:25], i_ins[11:8], 1'b0};
    assign imm_j = {{11{i_ins[31]}}, i_ins[31], i_ins[19:12], i_ins[20],
                    i_ins[30:21], 1'b0};
    assign imm_u = {i_ins[31:12], 12'd0};
    assign y     = (opc == OP_MATH) ? i_b : imm_i;
    assign sh    = y[4:0];
    assign pc4   = i_pc + 32'd4;

    always_comb begin
        o_res         = '0;
        o_res.rd      = i_ins[11:7];
        o_res.f3      = f3;
        o_res.npc     = pc4;
        o_res.halt    = i_halt;
        if (i_req_type == REQ_PRELOAD) begin
            o_res.npc = i_pc;
        end else if (i_halt || i_pc == 32'd0 || i_ins == 32'd0) begin
            // Stop for good; nothing else changes
            o_res.halt = 1'b1;
            o_res.npc  = i_pc;
        end else begin
            case (opc)
                OP_MATH, OP_MATHI: begin
                    o_res.wr = 1'b1;
                    case (f3)
                        F3_ADD:  o_res.val = (opc == OP_MATH && f7_nz) ? i_a - y : i_a + y;
                        F3_SLL:  o_res.val = i_a << sh;
                        F3_SLT:  o_res.val = {31'd0, $signed(i_a) < $signed(y)};
                        F3_SLTU: o_res.val = {31'd0, i_a < y};
                        F3_XOR:  o_res.val = i_a ^ y;
                        F3_SR:   o_res.val = f7_nz ? 32'($signed(i_a) >>> sh) : i_a >> sh;
                        F3_OR:   o_res.val = i_a | y;
                        default: o_res.val = i_a & y;
                    endcase
                end
                OP_STORE: begin
                    if (f3 inside {F3_B, F3_H, F3_W}) begin
                        o_res.store = 1'b1;
                        o_res.addr  = i_a + imm_s;
                    end else begin
                        o_res.unknown = 1'b1;
                    end
                end
                OP_LOAD: begin
                    if (f3 inside {F3_B, F3_H, F3_W, F3_BU, F3_HU}) begin
                        o_res.load = 1'b1;
                        o_res.wr   = 1'b1;
                        o_res.addr = i_a + imm_i;
                    end else begin
                        o_res.unknown = 1'b1;
                    end
                end
                OP_BRANCH: begin
                    case (f3)
                        F3_BEQ:  if (i_a == i_b) o_res.npc = i_pc + imm_b;
                        F3_BNE:  if (i_a != i_b) o_res.npc = i_pc + imm_b;
                        F3_BLT:  if ($signed(i_a) < $signed(i_b)) o_res.npc = i_pc + imm_b;
                        F3_BGE:  if ($signed(i_a) >= $signed(i_b)) o_res.npc = i_pc + imm_b;
                        F3_BLTU: if (i_a < i_b) o_res.npc = i_pc + imm_b;
                        F3_BGEU: if (i_a >= i_b) o_res.npc = i_pc + imm_b;
                        default: o_res.unknown = 1'b1;
                    endcase
                end
                OP_JALR: begin
                    o_res.wr  = 1'b1;
                    o_res.val = pc4;
                    o_res.npc = (i_a + imm_i) & ~32'd1;
                end
                OP_JAL: begin
                    o_res.wr  = 1'b1;
                    o_res.val = pc4;
                    o_res.npc = i_pc + imm_j;
                end
                OP_AUIPC: begin
                    o_res.wr  = 1'b1;
                    o_res.val = i_pc + imm_u;
                end
                OP_LUI: begin
                    o_res.wr  = 1'b1;
                    o_res.val = imm_u;
                end
                default: o_res.unknown = 1'b1;
            endcase
        end
    end

endmodule

// File: dv/rvx_retire_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rvx_retire_checker
// Watches the configuration, request and result channels of the RV32I execute
// block, keeps its own copy of the architectural state (PC, registers, data
// memory, halt flag) and compares every result with the predicted outcome.
// ----------------------------------------------------------------------------
module rvx_retire_checker
    import rvx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rvx_cfg_if   cfg,
    rvx_req_if   req,
    rvx_res_if   res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [31:0] npc;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        wr;
        logic        stored;
        logic [31:0] addr;
        logic        unknown;
        logic        halt;
    } t_retire;

    logic [31:0] base_q;
    logic [31:0] pc_q;
    logic [31:0] gpr[32];
    logic [31:0] dmem[C_MEM_WORDS];
    logic        halt_q;
    t_retire     retire_q[$];
    int          mismatches;

    // Word slot of a byte address, wrapped to the memory size
    function automatic logic [C_MEM_AW-1:0] mem_slot(input logic [31:0] addr);
        logic [31:0] ofs;
        ofs = addr - base_q;
        return ofs[C_MEM_AW+1:2];
    endfunction

    // Execute one request against the shadow state and return its outcome
    task automatic predict_retire(input logic ty, input logic [11:0] idx,
                                  input logic [31:0] word, input logic [31:0] ins,
                                  output t_retire o);
        logic [31:0] a, b, y, w, imm_i, imm_s, imm_b, imm_j, imm_u;
        logic [4:0]  rd, sh;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic        take, is_reg;
        logic [C_MEM_AW-1:0] slot;
        o     = '0;
        rd    = ins[11:7];
        f3    = ins[14:12];
        f7    = ins[31:25];
        a     = gpr[ins[19:15]];
        b     = gpr[ins[24:20]];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        imm_u = {ins[31:12], 12'h000};
        o.npc = pc_q + 32'd4;
        if (ty == REQ_PRELOAD) begin
            dmem[idx[C_MEM_AW-1:0]] = word;
            o.npc = pc_q;
        end else if (halt_q || pc_q == 32'd0 || ins == 32'd0) begin
            halt_q = 1'b1;
            o.npc  = pc_q;
        end else begin
            case (ins[6:0])
                OP_MATH, OP_MATHI: begin
                    is_reg = (ins[6:0] == OP_MATH);
                    y      = is_reg ? b : imm_i;
                    sh     = y[4:0];
                    o.wr   = 1'b1;
                    case (f3)
                        F3_ADD:  o.val = (is_reg && f7 != 0) ? a - y : a + y;
                        F3_SLL:  o.val = a << sh;
                        F3_SLT:  o.val = {31'd0, $signed(a) < $signed(y)};
                        F3_SLTU: o.val = {31'd0, a < y};
                        F3_XOR:  o.val = a ^ y;
                        F3_SR:   o.val = (f7 != 0) ? 32'($signed(a) >>> sh) : a >> sh;
                        F3_OR:   o.val = a | y;
                        default: o.val = a & y;
                    endcase
                end
                OP_STORE: begin
                    if (f3 > F3_W) begin
                        o.unknown = 1'b1;
                    end else begin
                        o.addr = a + imm_s;
                        slot   = mem_slot(o.addr);
                        w      = dmem[slot];
                        case (f3)
                            F3_B:    w[o.addr[1:0]*8 +: 8] = b[7:0];
                            F3_H:    w[o.addr[1]*16 +: 16] = b[15:0];
                            default: w = b;
                        endcase
                        dmem[slot] = w;
                        o.stored   = 1'b1;
                    end
                end
                OP_LOAD: begin
                    if (!(f3 inside {F3_B, F3_H, F3_W, F3_BU, F3_HU})) begin
                        o.unknown = 1'b1;
                    end else begin
                        o.addr = a + imm_i;
                        w      = dmem[mem_slot(o.addr)];
                        case (f3)
                            F3_B:    o.val = {{24{w[o.addr[1:0]*8+7]}}, w[o.addr[1:0]*8 +: 8]};
                            F3_BU:   o.val = {24'd0, w[o.addr[1:0]*8 +: 8]};
                            F3_H:    o.val = {{16{w[o.addr[1]*16+15]}}, w[o.addr[1]*16 +: 16]};
                            F3_HU:   o.val = {16'd0, w[o.addr[1]*16 +: 16]};
                            default: o.val = w;
                        endcase
                        o.wr = 1'b1;
                    end
                end
                OP_BRANCH: begin
                    case (f3)
                        F3_BEQ:  take = (a == b);
                        F3_BNE:  take = (a != b);
                        F3_BLT:  take = $signed(a) < $signed(b);
                        F3_BGE:  take = $signed(a) >= $signed(b);
                        F3_BLTU: take = a < b;
                        F3_BGEU: take = a >= b;
                        default: begin
                            take      = 1'b0;
                            o.unknown = 1'b1;
                        end
                    endcase
                    if (take) o.npc = pc_q + imm_b;
                end
                OP_JALR: begin
                    o.wr  = 1'b1;
                    o.val = pc_q + 32'd4;
                    o.npc = (a + imm_i) & ~32'd1;
                end
                OP_JAL: begin
                    o.wr  = 1'b1;
                    o.val = pc_q + 32'd4;
                    o.npc = pc_q + imm_j;
                end
                OP_AUIPC: begin
                    o.wr  = 1'b1;
                    o.val = pc_q + imm_u;
                end
                OP_LUI: begin
                    o.wr  = 1'b1;
                    o.val = imm_u;
                end
                default: o.unknown = 1'b1;
            endcase
            if (o.wr && rd != 0) gpr[rd] = o.val;
            pc_q = o.npc;
        end
        if (o.wr) begin
            o.rd = rd;
        end else begin
            o.val = '0;
        end
        o.wr   = o.wr && (rd != 0);
        o.halt = halt_q;
    endtask

    // Report one field that differs; only the first few are printed
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch on %s: expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // Follow the three channels; results are retired before new requests
    always @(posedge i_clk) begin
        t_retire exp_r;
        t_retire got_r;
        if (!i_rst_n) begin
            base_q = '0;
            pc_q   = '0;
            halt_q = 1'b0;
            for (int i = 0; i < 32; i++) gpr[i] = '0;
            gpr[2] = C_STACK_OFS;
            retire_q.delete();
            mismatches = 0;
        end else begin
            if (res.valid && res.ready) begin
                got_r = '{res.next_pc, res.dest_index, res.dest_value, res.dest_written,
                          res.store_done, res.access_address, res.unknown_op, res.halted};
                if (retire_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with no request outstanding", $time);
                end else begin
                    exp_r = retire_q.pop_front();
                    check_field("next_pc", exp_r.npc, got_r.npc);
                    check_field("dest_index", exp_r.rd, got_r.rd);
                    check_field("dest_value", exp_r.val, got_r.val);
                    check_field("dest_written", exp_r.wr, got_r.wr);
                    check_field("store_done", exp_r.stored, got_r.stored);
                    check_field("access_address", exp_r.addr, got_r.addr);
                    check_field("unknown_op", exp_r.unknown, got_r.unknown);
                    check_field("halted", exp_r.halt, got_r.halt);
                end
            end
            if (cfg.valid && cfg.ready) begin
                base_q = cfg.memory_base;
                pc_q   = cfg.memory_base;
                gpr[2] = cfg.memory_base + C_STACK_OFS;
            end
            if (req.valid && req.ready) begin
                predict_retire(req.req_type, req.preload_index, req.preload_word,
                               req.instruction, exp_r);
                retire_q.push_back(exp_r);
            end
        end
        o_pending    <= retire_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: dv/tb_rv32i_instruction_execute.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rv32i_instruction_execute
// Fills the load/store window of the data memory, then runs directed and
// random RV32I instruction streams under several memory bases with random
// request gaps and result stalls, and finishes by driving the block into its
// halt state.
// ----------------------------------------------------------------------------
module tb_rv32i_instruction_execute;
    import rvx_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 95;

    typedef enum int {
        K_MATH, K_MATHI, K_LOAD, K_STORE, K_BRANCH,
        K_JALR, K_JAL, K_AUIPC, K_LUI, K_NOISE
    } t_kind;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic burst = 1'b0;
    int   res_stall = 0;
    int   idle_cycles = 0;
    int   fail_count;
    int   pending;

    rvx_cfg_if cfg_if ();
    rvx_req_if req_if ();
    rvx_res_if res_if ();

    rv32i_instruction_execute dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    rvx_retire_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cfg          (cfg_if),
        .req          (req_if),
        .res          (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Known values on every input from time zero
    initial begin
        cfg_if.valid         = 1'b0;
        cfg_if.memory_base   = '0;
        req_if.valid         = 1'b0;
        req_if.req_type      = REQ_PRELOAD;
        req_if.preload_index = '0;
        req_if.preload_word  = '0;
        req_if.instruction   = '0;
        res_if.ready         = 1'b0;
    end

    // Result side: random stall after each result, none in burst phases
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (res_if.valid && res_if.ready) begin
            res_stall = burst ? 0 : $urandom_range(0, 4);
            res_if.ready <= (res_stall == 0);
        end else if (res_stall > 0) begin
            res_stall--;
            res_if.ready <= (res_stall == 0);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Drop the run if no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Build an instruction of the given class with random fields
    function automatic logic [31:0] make_insn(input t_kind kind);
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [11:0] imm;
        logic [31:0] ins;
        rd  = $urandom_range(0, 31);
        rs1 = $urandom_range(0, 31);
        rs2 = $urandom_range(0, 31);
        f3  = $urandom_range(0, 7);
        imm = $urandom;
        case ($urandom_range(0, 3))
            0:       f7 = $urandom;
            1, 2:    f7 = 7'h20;
            default: f7 = 7'h00;
        endcase
        case (kind)
            K_MATH:   ins = {f7, rs2, rs1, f3, rd, OP_MATH};
            K_MATHI:  ins = {imm, rs1, f3, rd, OP_MATHI};
            K_LOAD:   ins = {imm, rs1, f3, rd, OP_LOAD};
            K_STORE:  ins = {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
            K_BRANCH: ins = {imm[11:5], rs2, rs1, f3, imm[4:0], OP_BRANCH};
            K_JALR:   ins = {imm, rs1, f3, rd, OP_JALR};
            K_JAL:    ins = {20'($urandom), rd, OP_JAL};
            K_AUIPC:  ins = {20'($urandom), rd, OP_AUIPC};
            K_LUI:    ins = {20'($urandom), rd, OP_LUI};
            default:  ins = $urandom;
        endcase
        // keep the stack register fixed; every memory access is based on it
        if (ins[11:7] == 5'd2) ins[11:7] = 5'd3;
        // hold loads and stores within 64 bytes of the stack register
        if (ins[6:0] == OP_LOAD || ins[6:0] == OP_STORE) begin
            ins[19:15] = 5'd2;
            ins[30:26] = {5{ins[31]}};
        end
        // keep a zero word away from the stream until the halt phase
        if (ins == 32'd0) ins = 32'd1;
        return ins;
    endfunction

    // Send one request after a random gap and wait for it to be taken
    task automatic send_req(input logic ty, input logic [11:0] idx,
                            input logic [31:0] word, input logic [31:0] ins);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.req_type      <= ty;
        req_if.preload_index <= idx;
        req_if.preload_word  <= word;
        req_if.instruction   <= ins;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
    endtask

    task automatic exec_insn(input logic [31:0] ins);
        send_req(REQ_EXEC, 12'($urandom), $urandom, ins);
    endtask

    // Drain all results, let the pipeline settle, then write the base register
    task automatic write_base(input logic [31:0] value);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.memory_base <= value;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly well-formed instructions, some preloads and raw noise
    task automatic random_items(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       send_req(REQ_PRELOAD, 12'($urandom), $urandom, $urandom);
            else if (pick < 28) exec_insn(make_insn(K_MATH));
            else if (pick < 45) exec_insn(make_insn(K_MATHI));
            else if (pick < 57) exec_insn(make_insn(K_LOAD));
            else if (pick < 69) exec_insn(make_insn(K_STORE));
            else if (pick < 78) exec_insn(make_insn(K_BRANCH));
            else if (pick < 82) exec_insn(make_insn(K_JALR));
            else if (pick < 86) exec_insn(make_insn(K_JAL));
            else if (pick < 89) exec_insn(make_insn(K_AUIPC));
            else if (pick < 95) exec_insn(make_insn(K_LUI));
            else                exec_insn(make_insn(K_NOISE));
        end
    endtask

    initial begin
        logic [31:0] bases[4];
        bases = '{32'h0000_1000, 32'h8000_0000, $urandom | 32'h0010_0000, 32'hFFF0_0000};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the words around the stack register that loads and stores reach
        burst = 1'b1;
        for (int i = 0; i < 16; i++) begin
            send_req(REQ_PRELOAD, 12'(i), $urandom, '0);
            send_req(REQ_PRELOAD, 12'(C_MEM_WORDS - 16 + i), $urandom, '0);
        end
        send_req(REQ_PRELOAD, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_PRELOAD, 12'h000, 32'h8000_0001, '0);
        burst = 1'b0;

        for (int p = 0; p < 4; p++) begin
            write_base(bases[p]);
            if (p == 0) begin
                // base reload check: AUIPC reads the PC, ADDI reads the stack register
                exec_insn({20'h00000, 5'd1, OP_AUIPC});
                exec_insn({12'h000, 5'd2, F3_ADD, 5'd3, OP_MATHI});
                exec_insn({20'hFFFFF, 5'd5, OP_LUI});
                exec_insn({12'h800, 5'd0, F3_ADD, 5'd6, OP_MATHI});
                exec_insn({12'h7FF, 5'd6, F3_ADD, 5'd7, OP_MATHI});
                exec_insn({12'h403, 5'd5, F3_SR, 5'd8, OP_MATHI});
                exec_insn({7'h20, 5'd6, 5'd5, F3_ADD, 5'd9, OP_MATH});
                // odd jump target loses bit 0
                exec_insn({12'h009, 5'd1, F3_ADD, 5'd10, OP_JALR});
                for (int k = K_MATH; k <= K_NOISE; k++) begin
                    exec_insn(make_insn(t_kind'(k)));
                    exec_insn(make_insn(t_kind'(k)));
                end
            end
            burst = (p == 2);
            random_items(PHASE_ITEMS);
            burst = 1'b0;
        end

        // Halt: either the PC wraps to zero or a zero instruction arrives
        if ($urandom_range(0, 1) == 0) begin
            write_base(32'hFFFF_FFF8);
            exec_insn({12'h001, 5'd0, F3_ADD, 5'd4, OP_MATHI});
            exec_insn({12'h001, 5'd0, F3_ADD, 5'd4, OP_MATHI});
        end else begin
            exec_insn(32'd0);
        end
        exec_insn(make_insn(K_MATH));
        send_req(REQ_PRELOAD, 12'h123, $urandom, '0);
        exec_insn(make_insn(K_LOAD));
        write_base(32'h0000_0000);
        exec_insn(make_insn(K_LUI));
        exec_insn(32'd0);

        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
